// ===== hdl/ssm_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and microcode table for the sparse set block
package ssm_pkg;

	localparam int INDEX_BITS_DEF  = 12;
	localparam int CAPACITY_DEF    = 1024;
	localparam int HANDLE_BITS_DEF = 32;

	localparam int ENTITY_W  = 32;
	localparam int CMD_W     = 3;
	localparam int POS_OUT_W = 10;
	localparam int CNT_OUT_W = 11;
	localparam int STATUS_W  = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT   = 3'd0,
		CMD_REMOVE   = 3'd1,
		CMD_CONTAINS = 3'd2,
		CMD_LOOKUP   = 3'd3,
		CMD_CLEAR    = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_PRESENT = 2'd1,
		ST_ABSENT  = 2'd2,
		ST_FULL    = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		STEP_FETCH,
		STEP_DREAD,
		STEP_DISPATCH,
		STEP_INSERT,
		STEP_REMOVE,
		STEP_CONTAINS,
		STEP_LOOKUP,
		STEP_CLEAR,
		STEP_NOP
	} step_t;

	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_ACCEPT,
		JMP_DISPATCH,
		JMP_EMIT
	} jump_t;

	typedef enum logic {
		DRD_SLOT,
		DRD_LAST
	} dsel_t;

	typedef enum logic [2:0] {
		RES_NONE,
		RES_INSERT,
		RES_REMOVE,
		RES_CONTAINS,
		RES_LOOKUP,
		RES_CLEAR,
		RES_NOP
	} res_t;

	typedef struct packed {
		step_t next_step;
		jump_t jump;
		logic  in_ready;
		logic  sparse_rd;
		logic  dense_rd;
		dsel_t dense_sel;
		logic  latch_slot;
		logic  latch_check;
		res_t  op;
	} ucode_t;

	typedef struct packed {
		cmd_t cmd;
		logic out_free;
	} dp_stat_t;

	// control store: one word per step
	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t w;
		w = '{next_step: STEP_FETCH, jump: JMP_NEXT, in_ready: 1'b0, sparse_rd: 1'b0,
			dense_rd: 1'b0, dense_sel: DRD_SLOT, latch_slot: 1'b0, latch_check: 1'b0,
			op: RES_NONE};
		unique case (step)
			STEP_FETCH: begin
				w.next_step = STEP_DREAD;
				w.jump      = JMP_ACCEPT;
				w.in_ready  = 1'b1;
				w.sparse_rd = 1'b1;
			end
			STEP_DREAD: begin
				w.next_step  = STEP_DISPATCH;
				w.dense_rd   = 1'b1;
				w.dense_sel  = DRD_SLOT;
				w.latch_slot = 1'b1;
			end
			STEP_DISPATCH: begin
				// fetch the last handle in case the command is a remove
				w.jump        = JMP_DISPATCH;
				w.dense_rd    = 1'b1;
				w.dense_sel   = DRD_LAST;
				w.latch_check = 1'b1;
			end
			STEP_INSERT: begin
				w.jump = JMP_EMIT;
				w.op   = RES_INSERT;
			end
			STEP_REMOVE: begin
				w.jump = JMP_EMIT;
				w.op   = RES_REMOVE;
			end
			STEP_CONTAINS: begin
				w.jump = JMP_EMIT;
				w.op   = RES_CONTAINS;
			end
			STEP_LOOKUP: begin
				w.jump = JMP_EMIT;
				w.op   = RES_LOOKUP;
			end
			STEP_CLEAR: begin
				w.jump = JMP_EMIT;
				w.op   = RES_CLEAR;
			end
			STEP_NOP: begin
				w.jump = JMP_EMIT;
				w.op   = RES_NOP;
			end
			default: begin
				w.next_step = STEP_FETCH;
			end
		endcase
		return w;
	endfunction

endpackage

// ===== hdl/ssm_sequencer.sv =====
`timescale 1ns / 1ps
// step counter and control store lookup for the sparse set block
module ssm_sequencer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  ssm_pkg::dp_stat_t stat,
	output ssm_pkg::ucode_t   ctrl
);

	ssm_pkg::step_t upc_q;
	ssm_pkg::step_t upc_d;

	always_comb begin
		ctrl = ssm_pkg::ucode_rom(upc_q);
	end

	always_comb begin
		unique case (ctrl.jump)
			ssm_pkg::JMP_NEXT: begin
				upc_d = ctrl.next_step;
			end
			ssm_pkg::JMP_ACCEPT: begin
				upc_d = in_valid ? ctrl.next_step : upc_q;
			end
			ssm_pkg::JMP_EMIT: begin
				// hold the command step until the output register frees up
				upc_d = stat.out_free ? ctrl.next_step : upc_q;
			end
			ssm_pkg::JMP_DISPATCH: begin
				unique case (stat.cmd)
					ssm_pkg::CMD_INSERT:   upc_d = ssm_pkg::STEP_INSERT;
					ssm_pkg::CMD_REMOVE:   upc_d = ssm_pkg::STEP_REMOVE;
					ssm_pkg::CMD_CONTAINS: upc_d = ssm_pkg::STEP_CONTAINS;
					ssm_pkg::CMD_LOOKUP:   upc_d = ssm_pkg::STEP_LOOKUP;
					ssm_pkg::CMD_CLEAR:    upc_d = ssm_pkg::STEP_CLEAR;
					default:               upc_d = ssm_pkg::STEP_NOP;
				endcase
			end
			default: begin
				upc_d = ssm_pkg::STEP_FETCH;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= ssm_pkg::STEP_FETCH;
		end else begin
			upc_q <= upc_d;
		end
	end

endmodule

// ===== hdl/ssm_datapath.sv =====
`timescale 1ns / 1ps
// sparse and dense stores, member count and result register
module ssm_datapath #(
	parameter int INDEX_BITS  = ssm_pkg::INDEX_BITS_DEF,
	parameter int CAPACITY    = ssm_pkg::CAPACITY_DEF,
	parameter int HANDLE_BITS = ssm_pkg::HANDLE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ssm_pkg::ucode_t                 ctrl,
	input  logic                            accept,
	input  logic [ssm_pkg::ENTITY_W-1:0]    entity,
	input  logic [ssm_pkg::CMD_W-1:0]       cmd,
	input  logic                            out_take,
	output ssm_pkg::dp_stat_t               stat,
	output logic                            out_valid,
	output logic                            found,
	output logic [ssm_pkg::POS_OUT_W-1:0]   position,
	output logic [ssm_pkg::CNT_OUT_W-1:0]   count,
	output logic [ssm_pkg::STATUS_W-1:0]    status
);

	localparam int SPARSE_DEPTH = 1 << INDEX_BITS;
	localparam int POS_W        = $clog2(CAPACITY);
	localparam int CNT_W        = $clog2(CAPACITY + 1);
	localparam int WIDE_W       = (HANDLE_BITS > INDEX_BITS) ? HANDLE_BITS : INDEX_BITS;

	function automatic logic [INDEX_BITS-1:0] index_of(input logic [HANDLE_BITS-1:0] h);
		logic [WIDE_W-1:0] w;
		w = WIDE_W'(h);
		return w[INDEX_BITS-1:0];
	endfunction

	logic [POS_W-1:0]       sparse_mem [SPARSE_DEPTH];
	logic [HANDLE_BITS-1:0] dense_mem  [CAPACITY];

	logic [POS_W-1:0]       sparse_rd_q;
	logic [HANDLE_BITS-1:0] dense_rd_q;

	ssm_pkg::cmd_t          cmd_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic [POS_W-1:0]       slot_q;
	logic                   valid_q;
	logic                   match_q;
	logic [CNT_W-1:0]       count_q;

	logic                   out_valid_q;
	logic                   found_q;
	logic [POS_W-1:0]       pos_q;
	logic [CNT_W-1:0]       cnt_q;
	ssm_pkg::status_t       status_q;

	logic [HANDLE_BITS-1:0] in_handle;
	logic [INDEX_BITS-1:0]  in_idx;
	logic [INDEX_BITS-1:0]  idx_q;
	logic [CNT_W-1:0]       count_m1;
	logic [POS_W-1:0]       last;
	logic [POS_W-1:0]       dn_raddr;
	logic                   out_free;
	logic                   fire;
	logic                   full;
	logic                   hit;

	logic                   sp_we;
	logic [INDEX_BITS-1:0]  sp_waddr;
	logic [POS_W-1:0]       sp_wdata;
	logic                   dn_we;
	logic [POS_W-1:0]       dn_waddr;
	logic [HANDLE_BITS-1:0] dn_wdata;
	logic [CNT_W-1:0]       count_d;
	logic                   res_found;
	logic [POS_W-1:0]       res_pos;
	ssm_pkg::status_t       res_status;

	assign in_handle = HANDLE_BITS'(entity);
	assign in_idx    = index_of(in_handle);
	assign idx_q     = index_of(handle_q);
	assign count_m1  = count_q - CNT_W'(1);
	assign last      = count_m1[POS_W-1:0];
	assign dn_raddr  = (ctrl.dense_sel == ssm_pkg::DRD_SLOT) ? sparse_rd_q : last;
	assign out_free  = !out_valid_q || out_take;
	assign fire      = (ctrl.op != ssm_pkg::RES_NONE) && out_free;
	assign full      = (count_q == CNT_W'(CAPACITY));
	// entry is live only below the count and pointing back at the same index
	assign hit       = (CNT_W'(slot_q) < count_q) && (index_of(dense_rd_q) == idx_q);

	assign stat.cmd      = cmd_q;
	assign stat.out_free = out_free;

	always_comb begin
		sp_we      = 1'b0;
		sp_waddr   = idx_q;
		sp_wdata   = count_q[POS_W-1:0];
		dn_we      = 1'b0;
		dn_waddr   = count_q[POS_W-1:0];
		dn_wdata   = handle_q;
		count_d    = count_q;
		res_found  = 1'b0;
		res_pos    = '0;
		res_status = ssm_pkg::ST_OK;
		unique case (ctrl.op)
			ssm_pkg::RES_INSERT: begin
				priority if (valid_q) begin
					res_status = ssm_pkg::ST_PRESENT;
					res_pos    = slot_q;
				end else if (full) begin
					res_status = ssm_pkg::ST_FULL;
				end else begin
					sp_we   = 1'b1;
					dn_we   = 1'b1;
					res_pos = count_q[POS_W-1:0];
					count_d = count_q + CNT_W'(1);
				end
			end
			ssm_pkg::RES_REMOVE: begin
				if (valid_q) begin
					// move the last handle into the hole; harmless when it is the hole
					sp_we    = 1'b1;
					sp_waddr = index_of(dense_rd_q);
					sp_wdata = slot_q;
					dn_we    = 1'b1;
					dn_waddr = slot_q;
					dn_wdata = dense_rd_q;
					res_pos  = slot_q;
					count_d  = count_m1;
				end else begin
					res_status = ssm_pkg::ST_ABSENT;
				end
			end
			ssm_pkg::RES_CONTAINS: begin
				if (match_q) begin
					res_found = 1'b1;
					res_pos   = slot_q;
				end else begin
					res_status = ssm_pkg::ST_ABSENT;
				end
			end
			ssm_pkg::RES_LOOKUP: begin
				if (valid_q) begin
					res_pos = slot_q;
				end else begin
					res_status = ssm_pkg::ST_ABSENT;
				end
			end
			ssm_pkg::RES_CLEAR: begin
				count_d = '0;
			end
			ssm_pkg::RES_NONE, ssm_pkg::RES_NOP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (sp_we && fire) begin
			sparse_mem[sp_waddr] <= sp_wdata;
		end
		if (ctrl.sparse_rd) begin
			sparse_rd_q <= sparse_mem[in_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (dn_we && fire) begin
			dense_mem[dn_waddr] <= dn_wdata;
		end
		if (ctrl.dense_rd) begin
			dense_rd_q <= dense_mem[dn_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			handle_q <= in_handle;
		end
		if (ctrl.latch_slot) begin
			slot_q <= sparse_rd_q;
		end
		if (ctrl.latch_check) begin
			valid_q <= hit;
			match_q <= hit && (dense_rd_q == handle_q);
		end
		if (fire) begin
			found_q  <= res_found;
			pos_q    <= res_pos;
			cnt_q    <= count_d;
			status_q <= res_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q       <= ssm_pkg::CMD_INSERT;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cmd_q <= ssm_pkg::cmd_t'(cmd);
			end
			if (fire) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign position  = ssm_pkg::POS_OUT_W'(pos_q);
	assign count     = ssm_pkg::CNT_OUT_W'(cnt_q);
	assign status    = status_q;

endmodule

// ===== hdl/sparse_set_membership.sv =====
`timescale 1ns / 1ps
// top level of the sparse set: stream ports, sequencer and datapath
// path: after accept the request passes the dense read and dispatch steps, then its command step
// writes the output register once that is free; no new request is taken until the four microcode
// steps (sparse read, dense read, check, command) around single-port stores are through
// reset: step counter to fetch, member count to zero, output register empty
// the sparse and dense stores are not cleared; no clearing pass is needed
module sparse_set_membership #(
	parameter int INDEX_BITS  = ssm_pkg::INDEX_BITS_DEF,
	parameter int CAPACITY    = ssm_pkg::CAPACITY_DEF,
	parameter int HANDLE_BITS = ssm_pkg::HANDLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // entity[31:0]
	input  logic [2:0]  s_tuser,  // cmd[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // found[0], position[10:1], count[21:11], status[23:22]
);

	ssm_pkg::ucode_t                     ctrl;
	ssm_pkg::dp_stat_t                   stat;
	logic                                accept;
	logic                                found;
	logic [ssm_pkg::POS_OUT_W-1:0]       position;
	logic [ssm_pkg::CNT_OUT_W-1:0]       count;
	logic [ssm_pkg::STATUS_W-1:0]        status;

	assign s_tready = ctrl.in_ready;
	assign accept   = s_tvalid && ctrl.in_ready;
	assign m_tdata  = {status, count, position, found};

	ssm_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	ssm_datapath #(
		.INDEX_BITS  (INDEX_BITS),
		.CAPACITY    (CAPACITY),
		.HANDLE_BITS (HANDLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.accept    (accept),
		.entity    (s_tdata),
		.cmd       (s_tuser),
		.out_take  (m_tready),
		.stat      (stat),
		.out_valid (m_tvalid),
		.found     (found),
		.position  (position),
		.count     (count),
		.status    (status)
	);

	// one request in flight at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("request accepted while the previous one is in flight");

	// every request reaches its command step after the dense read and dispatch steps
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ##2 (ctrl.op != ssm_pkg::RES_NONE))
		else $error("sequencer did not reach a command step");

	// a full report only comes with the count at capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (status == ssm_pkg::ST_FULL)) |->
		(count == ssm_pkg::CNT_OUT_W'(CAPACITY)))
		else $error("store full reported below capacity");

endmodule

// ===== dv/tb_sparse_set_membership.sv =====
`timescale 1ns / 1ps
// testbench for the sparse set block: directed, fill-to-full and random command streams
module tb_sparse_set_membership;
	import ssm_pkg::*;

	localparam int INDEX_W     = INDEX_BITS_DEF;
	localparam int SPARSE_N    = 1 << INDEX_W;
	localparam int CAP         = CAPACITY_DEF;
	localparam int HOLD_CYCLES = 400;

	// codes the block accepts but does nothing with
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	typedef struct packed {
		status_t              status;
		logic [CNT_OUT_W-1:0] count;
		logic [POS_OUT_W-1:0] pos;
		logic                 found;
	} set_result_t;

	typedef struct {
		set_result_t         res;
		logic [CMD_W-1:0]    cmd;
		logic [ENTITY_W-1:0] ent;
	} pending_t;

	// mirror of the set: sparse positions, dense handles, member count
	class membership_tracker;
		bit [POS_OUT_W-1:0] slot_of [SPARSE_N];
		bit [ENTITY_W-1:0]  handle_at [CAP];
		bit                 touched [SPARSE_N];
		int                 touched_list [$];
		int unsigned        members;
		pending_t           awaiting [$];

		function bit find_slot(input bit [INDEX_W-1:0] idx, output bit [POS_OUT_W-1:0] slot);
			slot = slot_of[idx];
			return (slot < members) && (handle_at[slot][INDEX_W-1:0] == idx);
		endfunction

		function int waiting_results();
			return awaiting.size();
		endfunction

		function void note_request(input logic [CMD_W-1:0] cmd, input logic [ENTITY_W-1:0] ent);
			pending_t           p;
			bit [INDEX_W-1:0]   idx;
			bit [POS_OUT_W-1:0] slot;
			bit [POS_OUT_W-1:0] last;
			bit [ENTITY_W-1:0]  moved;
			bit                 hit;
			idx = ent[INDEX_W-1:0];
			hit = find_slot(idx, slot);
			p.cmd = cmd;
			p.ent = ent;
			p.res = '{status: ST_OK, count: '0, pos: '0, found: 1'b0};
			case (cmd)
				CMD_INSERT: begin
					if (hit) begin
						p.res.status = ST_PRESENT;
						p.res.pos = slot;
					end else if (members >= CAP) begin
						p.res.status = ST_FULL;
					end else begin
						p.res.pos = members[POS_OUT_W-1:0];
						slot_of[idx] = members[POS_OUT_W-1:0];
						handle_at[members[POS_OUT_W-1:0]] = ent;
						members++;
						if (!touched[idx]) begin
							touched[idx] = 1'b1;
							touched_list.insert(touched_list.size(), int'(idx));
						end
					end
				end
				CMD_REMOVE: begin
					if (!hit) begin
						p.res.status = ST_ABSENT;
					end else begin
						last = POS_OUT_W'(members - 1);
						// last handle fills the hole
						if (slot != last) begin
							moved = handle_at[last];
							handle_at[slot] = moved;
							slot_of[moved[INDEX_W-1:0]] = slot;
						end
						members--;
						p.res.pos = slot;
					end
				end
				CMD_CONTAINS: begin
					if (hit && handle_at[slot] == ent) begin
						p.res.found = 1'b1;
						p.res.pos = slot;
					end else begin
						p.res.status = ST_ABSENT;
					end
				end
				CMD_LOOKUP: begin
					if (hit)
						p.res.pos = slot;
					else
						p.res.status = ST_ABSENT;
				end
				CMD_CLEAR: begin
					members = 0;
				end
				default: begin
				end
			endcase
			p.res.count = members[CNT_OUT_W-1:0];
			awaiting.insert(awaiting.size(), p);
		endfunction

		function bit check_result(input logic [23:0] data, output string msg);
			pending_t    p;
			set_result_t got;
			p = awaiting.pop_front();
			got = set_result_t'(data);
			msg = "";
			if (got.found !== p.res.found)
				msg = {msg, $sformatf(" found %b/%b", got.found, p.res.found)};
			if (got.pos !== p.res.pos)
				msg = {msg, $sformatf(" position %0d/%0d", got.pos, p.res.pos)};
			if (got.count !== p.res.count)
				msg = {msg, $sformatf(" count %0d/%0d", got.count, p.res.count)};
			if (got.status !== p.res.status)
				msg = {msg, $sformatf(" status %0d/%0d", got.status, p.res.status)};
			if (msg != "")
				msg = $sformatf("cmd %0d entity %h, got/expected:%s", p.cmd, p.ent, msg);
			return msg == "";
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	membership_tracker tracker = new();
	int errors = 0;
	int burst_left;
	bit gaps_on;
	int hold_asks = 0;

	sparse_set_membership dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #2 clk = ~clk;

	task report(input string msg);
		errors++;
		$display("ERROR at %0t: %s", $time, msg);
	endtask

	// offer one request, wait for accept, then maybe open a gap
	task send(input logic [CMD_W-1:0] cmd, input logic [ENTITY_W-1:0] ent);
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= ent;
		do @(posedge clk); while (!s_tready);
		tracker.note_request(cmd, ent);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if (gaps_on) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			gaps_on = $urandom_range(0, 3) != 0;
		end
	endtask

	task drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (tracker.waiting_results() != 0);
	endtask

	function logic [ENTITY_W-1:0] with_index(input int idx);
		logic [ENTITY_W-1:0] ent;
		ent = $urandom();
		ent[INDEX_W-1:0] = idx[INDEX_W-1:0];
		return ent;
	endfunction

	// an index the store has never been written at
	function int fresh_index();
		int idx;
		do idx = $urandom_range(0, SPARSE_N - 1); while (tracker.touched[idx[INDEX_W-1:0]]);
		return idx;
	endfunction

	function logic [ENTITY_W-1:0] member_handle();
		int unsigned pick;
		pick = $urandom_range(0, tracker.members - 1);
		return tracker.handle_at[pick[POS_OUT_W-1:0]];
	endfunction

	function logic [ENTITY_W-1:0] touched_handle();
		return with_index(tracker.touched_list[$urandom_range(0, tracker.touched_list.size() - 1)]);
	endfunction

	// a handle whose index was written once, if possible one that is not in the set now
	function logic [ENTITY_W-1:0] stale_handle();
		logic [ENTITY_W-1:0] ent;
		bit [POS_OUT_W-1:0]  slot;
		repeat (200) begin
			ent = touched_handle();
			if (!tracker.find_slot(ent[INDEX_W-1:0], slot))
				return ent;
		end
		return ent;
	endfunction

	task random_request();
		int r;
		logic [ENTITY_W-1:0] ent;
		r = $urandom_range(0, 99);
		if (tracker.members == 0 && r < 94 && $urandom_range(0, 1) == 0)
			r = 0;
		if (r < 34) begin
			if (tracker.members < CAP && (r < 14 || tracker.touched_list.size() == 0))
				send(CMD_INSERT, with_index(fresh_index()));
			else if (tracker.members > 0 && r < 24)
				send(CMD_INSERT, member_handle());
			else
				send(CMD_INSERT, touched_handle());
		end else if (r < 52) begin
			if (tracker.members > 0 && r < 48) begin
				ent = member_handle();
				send(CMD_REMOVE, r < 42 ? ent : with_index(ent[INDEX_W-1:0]));
			end else begin
				send(CMD_REMOVE, touched_handle());
			end
		end else if (r < 72) begin
			if (tracker.members > 0 && r < 62) begin
				send(CMD_CONTAINS, member_handle());
			end else if (tracker.members > 0 && r < 66) begin
				ent = member_handle();
				send(CMD_CONTAINS, with_index(ent[INDEX_W-1:0]));
			end else begin
				send(CMD_CONTAINS, touched_handle());
			end
		end else if (r < 94) begin
			if (tracker.members > 0 && r < 88) begin
				ent = member_handle();
				send(CMD_LOOKUP, with_index(ent[INDEX_W-1:0]));
			end else begin
				send(CMD_LOOKUP, touched_handle());
			end
		end else if (r < 97) begin
			send(CMD_SPARE_LO + CMD_W'($urandom_range(0, 2)), touched_handle());
		end else begin
			send(CMD_CLEAR, touched_handle());
		end
	endtask

	// receiver: rotating stall patterns, plus a long hold-off on request
	initial begin : receiver
		int mode;
		int left;
		int cyc;
		int holds_done;
		m_tready <= 1'b0;
		mode = 0;
		left = 0;
		cyc = 0;
		holds_done = 0;
		forever begin
			@(posedge clk);
			cyc++;
			if (hold_asks != holds_done) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
				m_tready <= 1'b1;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(32, 200);
				end
				left--;
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= (cyc % 7) < 4;
					default: m_tready <= $urandom_range(0, 3) == 0;
				endcase
			end
		end
	end

	always @(posedge clk) begin : result_check
		string msg;
		if (arst_n && m_tvalid && m_tready) begin
			if (tracker.waiting_results() == 0)
				report($sformatf("unexpected result %h", m_tdata));
			else if (!tracker.check_result(m_tdata, msg))
				report(msg);
		end
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		int k;
		logic [ENTITY_W-1:0] ent;
		bit [POS_OUT_W-1:0] slot;
		arst_n = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= CMD_INSERT;
		burst_left = 1;
		gaps_on = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every command, stale entries, clear
		send(CMD_INSERT, 32'h0000_0000);
		send(CMD_INSERT, 32'hFFFF_FFFF);
		send(CMD_INSERT, 32'hABCD_E000);
		send(CMD_CONTAINS, 32'hFFFF_FFFF);
		send(CMD_CONTAINS, 32'h1234_5FFF);
		send(CMD_LOOKUP, 32'h0000_0FFF);
		send(CMD_INSERT, 32'h5A5A_5123);
		send(CMD_REMOVE, 32'h7777_7000);
		send(CMD_LOOKUP, 32'h0000_0123);
		send(CMD_CONTAINS, 32'h5A5A_5123);
		send(CMD_REMOVE, 32'h0000_0000);
		send(CMD_CONTAINS, 32'h0000_0000);
		send(CMD_REMOVE, 32'hFFFF_FFFF);
		send(CMD_SPARE_LO, 32'h0000_0123);
		send(CMD_SPARE_MID, 32'hFFFF_F000);
		send(CMD_SPARE_HI, 32'h0000_0FFF);
		send(CMD_CLEAR, 32'h0000_0123);
		send(CMD_LOOKUP, 32'h5A5A_5123);
		send(CMD_INSERT, 32'h8000_0FFF);
		send(CMD_REMOVE, 32'h8000_0FFF);
		send(CMD_REMOVE, 32'h8000_0FFF);
		drain();

		for (k = 0; k < 300; k++)
			random_request();
		drain();

		// fill to capacity, with the receiver holding off at the start
		send(CMD_CLEAR, touched_handle());
		hold_asks++;
		while (tracker.members < CAP) begin
			if (tracker.members > 0 && $urandom_range(0, 9) == 0) begin
				send($urandom_range(0, 1) ? CMD_CONTAINS : CMD_LOOKUP, member_handle());
			end else begin
				do ent = with_index($urandom_range(0, SPARSE_N - 1));
				while (tracker.find_slot(ent[INDEX_W-1:0], slot));
				send(CMD_INSERT, ent);
			end
		end
		for (k = 0; k < 60; k++) begin
			case ($urandom_range(0, 4))
				0: send(CMD_INSERT, member_handle());
				1: send(CMD_INSERT, stale_handle());
				2: send(CMD_CONTAINS, member_handle());
				3: send(CMD_LOOKUP, member_handle());
				default: send(CMD_REMOVE, member_handle());
			endcase
		end
		drain();
		send(CMD_CLEAR, touched_handle());

		for (k = 0; k < 300; k++) begin
			if (k == 100)
				hold_asks++;
			random_request();
		end

		drain();
		repeat (16) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
